// ----- src/tlwlc_pkg.sv -----
// shared constants, types and helpers for the text line, word and letter counter
package tlwlc_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int LETTER_BINS    = 26;
  localparam int IDX_BITS       = 5;
  localparam int OUT_BITS       = 32;
  localparam int BYTE_BITS      = 8;
  localparam int TDATA_IN_BITS  = 8;
  localparam int TDATA_OUT_BITS = 104;

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(LETTER_BINS - 1);

  localparam logic [BYTE_BITS-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [BYTE_BITS-1:0] SPACE_BYTE   = 8'h20;
  localparam logic [BYTE_BITS-1:0] TAB_BYTE     = 8'h09;
  localparam logic [BYTE_BITS-1:0] CR_BYTE      = 8'h0D;
  localparam logic [BYTE_BITS-1:0] UPPER_A      = 8'h41;
  localparam logic [BYTE_BITS-1:0] UPPER_Z      = 8'h5A;
  localparam logic [BYTE_BITS-1:0] LOWER_A      = 8'h61;
  localparam logic [BYTE_BITS-1:0] LOWER_Z      = 8'h7A;
  localparam logic [BYTE_BITS-1:0] CASE_OFFSET  = 8'h20;

  typedef enum logic {
    ST_RUN,
    ST_REPORT
  } tlwlc_state_t;

  typedef struct packed {
    logic                count_en;
    logic                load;
    logic                clear;
    logic                last;
    logic [IDX_BITS-1:0] idx;
  } tlwlc_cmd_t;

  function automatic logic is_blank(input logic [BYTE_BITS-1:0] b);
    return (b == SPACE_BYTE) || ((b >= TAB_BYTE) && (b <= CR_BYTE));
  endfunction

endpackage

// ----- src/tlwlc_ctrl.sv -----
// controller: run/report sequencing, report index and output valid
module tlwlc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tlast,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output tlwlc_pkg::tlwlc_cmd_t cmd
);
  import tlwlc_pkg::*;

  tlwlc_state_t        state_r, state_nxt;
  logic [IDX_BITS-1:0] idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd.count_en  = 1'b0;
    cmd.load      = 1'b0;
    cmd.clear     = 1'b0;
    cmd.last      = (idx_r == LAST_IDX);
    cmd.idx       = idx_r;
    unique case (state_r)
      ST_RUN: begin
        in_tready    = 1'b1;
        cmd.count_en = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = ST_REPORT;
          idx_nxt   = '0;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          if (idx_r == LAST_IDX) begin
            // last item captured, counts may go back to zero
            cmd.clear = 1'b1;
            state_nxt = ST_RUN;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

endmodule

// ----- src/tlwlc_dp.sv -----
// datapath: saturating line, word and letter counters and the report register
module tlwlc_dp #(
  parameter int COUNT_BITS = tlwlc_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  tlwlc_pkg::tlwlc_cmd_t               cmd,
  input  logic [tlwlc_pkg::BYTE_BITS-1:0]     text_byte,
  input  logic                                rst_n,
  output logic [tlwlc_pkg::IDX_BITS-1:0]      letter_index,
  output logic [tlwlc_pkg::OUT_BITS-1:0]      letter_count,
  output logic [tlwlc_pkg::OUT_BITS-1:0]      line_count,
  output logic [tlwlc_pkg::OUT_BITS-1:0]      word_count,
  output logic                                last_of_report
);
  import tlwlc_pkg::*;

  localparam int EXT_BITS = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [COUNT_BITS-1:0] lines_r, lines_nxt;
  logic [COUNT_BITS-1:0] words_r, words_nxt;
  logic                  in_word_r, in_word_nxt;
  logic [COUNT_BITS-1:0] hist_r   [LETTER_BINS];
  logic [COUNT_BITS-1:0] hist_nxt [LETTER_BINS];

  logic [IDX_BITS-1:0]  index_r;
  logic [OUT_BITS-1:0]  letter_r, line_r, word_r;
  logic                 last_r;

  logic                 blank;
  logic [BYTE_BITS-1:0] folded;
  logic [BYTE_BITS-1:0] bin_full;
  logic                 letter_hit;
  logic [IDX_BITS-1:0]  bin;
  logic [EXT_BITS-1:0]  letter_ext, line_ext, word_ext;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  assign blank      = is_blank(text_byte);
  assign folded     = ((text_byte >= UPPER_A) && (text_byte <= UPPER_Z)) ?
                      text_byte + CASE_OFFSET : text_byte;
  assign letter_hit = (folded >= LOWER_A) && (folded <= LOWER_Z);
  assign bin_full   = folded - LOWER_A;
  assign bin        = bin_full[IDX_BITS-1:0];

  always_comb begin
    lines_nxt   = lines_r;
    words_nxt   = words_r;
    in_word_nxt = in_word_r;
    for (int k = 0; k < LETTER_BINS; k++) begin
      hist_nxt[k] = hist_r[k];
    end
    if (cmd.clear) begin
      lines_nxt   = '0;
      words_nxt   = '0;
      in_word_nxt = 1'b0;
      for (int k = 0; k < LETTER_BINS; k++) begin
        hist_nxt[k] = '0;
      end
    end else if (cmd.count_en) begin
      if (text_byte == NEWLINE_BYTE) begin
        lines_nxt = sat_inc(lines_r);
      end
      if (blank) begin
        in_word_nxt = 1'b0;
      end else if (!in_word_r) begin
        // entering a word
        words_nxt   = sat_inc(words_r);
        in_word_nxt = 1'b1;
      end
      for (int k = 0; k < LETTER_BINS; k++) begin
        if (letter_hit && (bin == IDX_BITS'(k))) begin
          hist_nxt[k] = sat_inc(hist_r[k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lines_r   <= '0;
      words_r   <= '0;
      in_word_r <= 1'b0;
      for (int k = 0; k < LETTER_BINS; k++) begin
        hist_r[k] <= '0;
      end
    end else begin
      lines_r   <= lines_nxt;
      words_r   <= words_nxt;
      in_word_r <= in_word_nxt;
      for (int k = 0; k < LETTER_BINS; k++) begin
        hist_r[k] <= hist_nxt[k];
      end
    end
  end

  // counters narrower than the output are zero-extended, wider ones keep the low bits
  assign letter_ext = EXT_BITS'(hist_r[cmd.idx]);
  assign line_ext   = EXT_BITS'(lines_r);
  assign word_ext   = EXT_BITS'(words_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      index_r  <= cmd.idx;
      letter_r <= letter_ext[OUT_BITS-1:0];
      line_r   <= line_ext[OUT_BITS-1:0];
      word_r   <= word_ext[OUT_BITS-1:0];
      last_r   <= cmd.last;
    end
  end

  assign letter_index   = index_r;
  assign letter_count   = letter_r;
  assign line_count     = line_r;
  assign word_count     = word_r;
  assign last_of_report = last_r;

endmodule

// ----- src/text_line_word_letter_counter.sv -----
// top level of the text line, word and letter counter
// Takes one text byte per cycle while counting: newlines as lines, each move from
// whitespace (space, 0x09..0x0D) into any other byte as a word, and letters folded
// to lower case into 26 bins; all counters saturate. The byte with in_tlast set is
// counted, then the block sends 26 report transactions, letter a first, each with
// the line and word totals, out_tlast on letter z. Input is held off while the
// report drains, as the single output register steps through the bins. Counts
// clear as the last report item is loaded, so the next text may start while that
// item still waits to be taken.
module text_line_word_letter_counter #(
  parameter int COUNT_BITS = tlwlc_pkg::COUNT_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [tlwlc_pkg::TDATA_IN_BITS-1:0]     in_tdata,   // [7:0] text_byte
  input  logic                                    in_tlast,   // end_of_text
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // [4:0] letter_index, [36:5] letter_count, [68:37] line_count,
  // [100:69] word_count, [103:101] zero
  output logic [tlwlc_pkg::TDATA_OUT_BITS-1:0]    out_tdata,
  output logic                                    out_tlast   // last_of_report
);
  import tlwlc_pkg::*;

  localparam int PAD_BITS = TDATA_OUT_BITS - IDX_BITS - 3 * OUT_BITS;

  tlwlc_cmd_t          cmd;
  logic [IDX_BITS-1:0] letter_index;
  logic [OUT_BITS-1:0] letter_count, line_count, word_count;

  tlwlc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  tlwlc_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .text_byte      (in_tdata[BYTE_BITS-1:0]),
    .rst_n          (rst_n),
    .letter_index   (letter_index),
    .letter_count   (letter_count),
    .line_count     (line_count),
    .word_count     (word_count),
    .last_of_report (out_tlast)
  );

  assign out_tdata = {{PAD_BITS{1'b0}}, word_count, line_count, letter_count, letter_index};

endmodule
